// ===== design/c2p_pkg.sv =====
package c2p_pkg;

  localparam int GUARD_BITS = 28;
  localparam int Z_WIDTH = 34;
  localparam int ANGLE_WIDTH = 16;

  localparam logic [ANGLE_WIDTH-1:0] TURN_ZERO = 16'd0;
  localparam logic [ANGLE_WIDTH-1:0] TURN_QUARTER = 16'd16384;
  localparam logic [ANGLE_WIDTH-1:0] TURN_HALF = 16'd32768;
  localparam logic [ANGLE_WIDTH-1:0] TURN_3QUARTER = 16'd49152;

  // atan(2^-i) in units of 2^-32 turn, rounded.
  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef struct packed {
    logic valid;
    logic x_zero;
    logic y_zero;
    logic x_neg;
    logic y_neg;
  } ctrl_t;

endpackage

// ===== design/c2p_front.sv =====
module c2p_front
  import c2p_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic signed [COORD_WIDTH-1:0]   x_coord,
  input  logic signed [COORD_WIDTH-1:0]   y_coord,
  output ctrl_t                           ctl_out,
  output logic [2*COORD_WIDTH-1:0]        sum_out,
  output logic [COORD_WIDTH-1:0]          ax_out,
  output logic [COORD_WIDTH-1:0]          ay_out
);

  localparam int SW = 2 * COORD_WIDTH;

  ctrl_t ctl1, ctl2, ctl3;
  logic [COORD_WIDTH-1:0] ax1, ay1, ax2, ay2, ax3, ay3;
  logic [SW-1:0] sq_x, sq_y, sum3;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid <= 1'b0;
      ctl2.valid <= 1'b0;
      ctl3.valid <= 1'b0;
    end else begin
      ctl1.valid <= accept;
      ctl2.valid <= ctl1.valid;
      ctl3.valid <= ctl2.valid;
    end
    ctl1.x_zero <= (x_coord == '0);
    ctl1.y_zero <= (y_coord == '0);
    ctl1.x_neg  <= x_coord[COORD_WIDTH-1];
    ctl1.y_neg  <= y_coord[COORD_WIDTH-1];
    ctl2.x_zero <= ctl1.x_zero;
    ctl2.y_zero <= ctl1.y_zero;
    ctl2.x_neg  <= ctl1.x_neg;
    ctl2.y_neg  <= ctl1.y_neg;
    ctl3.x_zero <= ctl2.x_zero;
    ctl3.y_zero <= ctl2.y_zero;
    ctl3.x_neg  <= ctl2.x_neg;
    ctl3.y_neg  <= ctl2.y_neg;
    // The most negative input negates to itself, which reads correctly as unsigned.
    ax1 <= x_coord[COORD_WIDTH-1] ? COORD_WIDTH'(-x_coord) : COORD_WIDTH'(x_coord);
    ay1 <= y_coord[COORD_WIDTH-1] ? COORD_WIDTH'(-y_coord) : COORD_WIDTH'(y_coord);
    sq_x <= ax1 * ax1;
    sq_y <= ay1 * ay1;
    ax2 <= ax1;
    ay2 <= ay1;
    sum3 <= sq_x + sq_y;
    ax3 <= ax2;
    ay3 <= ay2;
  end

  assign ctl_out = ctl3;
  assign sum_out = sum3;
  assign ax_out = ax3;
  assign ay_out = ay3;

endmodule

// ===== design/c2p_cell.sv =====
module c2p_cell
  import c2p_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int ITERATIONS = 16,
  parameter int STEP = 0
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  ctrl_t                                        ctl_in,
  input  logic [2*COORD_WIDTH-1:0]                     rem_in,
  input  logic [2*COORD_WIDTH-1:0]                     root_in,
  input  logic signed [COORD_WIDTH+GUARD_BITS+3:0]     cx_in,
  input  logic signed [COORD_WIDTH+GUARD_BITS+3:0]     cy_in,
  input  logic signed [Z_WIDTH-1:0]                    z_in,
  output ctrl_t                                        ctl_out,
  output logic [2*COORD_WIDTH-1:0]                     rem_out,
  output logic [2*COORD_WIDTH-1:0]                     root_out,
  output logic signed [COORD_WIDTH+GUARD_BITS+3:0]     cx_out,
  output logic signed [COORD_WIDTH+GUARD_BITS+3:0]     cy_out,
  output logic signed [Z_WIDTH-1:0]                    z_out
);

  localparam int SW = 2 * COORD_WIDTH;
  localparam int CW = COORD_WIDTH + GUARD_BITS + 4;
  localparam bit DO_SQRT = (STEP < COORD_WIDTH);
  localparam bit DO_CORDIC = (STEP < ITERATIONS);
  localparam int SQ_SHIFT = DO_SQRT ? 2 * (COORD_WIDTH - 1 - STEP) : 0;
  localparam logic [SW-1:0] SQ_BIT = DO_SQRT ? (SW'(1) << SQ_SHIFT) : '0;
  localparam int ATAN_IDX = DO_CORDIC ? STEP : 0;
  localparam logic signed [Z_WIDTH-1:0] ATAN_STEP =
    $signed({{(Z_WIDTH-32){1'b0}}, ATAN_TURNS[ATAN_IDX]});

  logic [SW:0] trial;
  logic [SW-1:0] rem_next, root_next;
  logic signed [CW-1:0] dx, dy, cx_next, cy_next;
  logic signed [Z_WIDTH-1:0] z_next;

  // Up to one restoring square root bit and one CORDIC micro-rotation per cell.
  always_comb begin
    trial = {1'b0, root_in} + {1'b0, SQ_BIT};
    rem_next = rem_in;
    root_next = root_in;
    if (DO_SQRT) begin
      if ({1'b0, rem_in} >= trial) begin
        rem_next = rem_in - trial[SW-1:0];
        root_next = (root_in >> 1) + SQ_BIT;
      end else begin
        root_next = root_in >> 1;
      end
    end
    dx = cy_in >>> STEP;
    dy = cx_in >>> STEP;
    cx_next = cx_in;
    cy_next = cy_in;
    z_next = z_in;
    if (DO_CORDIC) begin
      if (!cy_in[CW-1]) begin
        cx_next = cx_in + dx;
        cy_next = cy_in - dy;
        z_next = z_in + ATAN_STEP;
      end else begin
        cx_next = cx_in - dx;
        cy_next = cy_in + dy;
        z_next = z_in - ATAN_STEP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    ctl_out.x_zero <= ctl_in.x_zero;
    ctl_out.y_zero <= ctl_in.y_zero;
    ctl_out.x_neg <= ctl_in.x_neg;
    ctl_out.y_neg <= ctl_in.y_neg;
    rem_out <= rem_next;
    root_out <= root_next;
    cx_out <= cx_next;
    cy_out <= cy_next;
    z_out <= z_next;
  end

endmodule

// ===== design/c2p_back.sv =====
module c2p_back
  import c2p_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ctrl_t                           ctl_in,
  input  logic [2*COORD_WIDTH-1:0]        rem_in,
  input  logic [2*COORD_WIDTH-1:0]        root_in,
  input  logic signed [Z_WIDTH-1:0]       z_in,
  output logic                            done,
  output logic [COORD_WIDTH-1:0]          magnitude,
  output logic [ANGLE_WIDTH-1:0]          angle_turns
);

  localparam int SW = 2 * COORD_WIDTH;
  localparam logic [30:0] Z_MAX = 31'h4000_0000;

  logic [SW-1:0] root_round;
  logic [30:0] z_clamp;
  logic [31:0] z_round;
  logic [ANGLE_WIDTH-1:0] a_raw, a_quad, angle_next;
  logic [COORD_WIDTH-1:0] magnitude_next;

  always_comb begin
    // The remainder exceeds the root exactly when the square lies past (root + 1/2)^2.
    root_round = root_in + SW'(rem_in > root_in);
    magnitude_next = ctl_in.x_zero && ctl_in.y_zero ? '0 : root_round[COORD_WIDTH-1:0];

    if (z_in[Z_WIDTH-1]) begin
      z_clamp = '0;
    end else if (z_in > $signed({{(Z_WIDTH-31){1'b0}}, Z_MAX})) begin
      z_clamp = Z_MAX;
    end else begin
      z_clamp = z_in[30:0];
    end
    z_round = {1'b0, z_clamp} + 32'd32768;
    a_raw = z_round[31:16];
    a_quad = (a_raw > TURN_QUARTER) ? TURN_QUARTER : a_raw;

    if (ctl_in.x_zero && ctl_in.y_zero) begin
      angle_next = TURN_ZERO;
    end else if (ctl_in.x_zero) begin
      angle_next = ctl_in.y_neg ? TURN_3QUARTER : TURN_QUARTER;
    end else if (ctl_in.y_zero) begin
      angle_next = ctl_in.x_neg ? TURN_HALF : TURN_ZERO;
    end else if (!ctl_in.x_neg && !ctl_in.y_neg) begin
      angle_next = a_quad;
    end else if (ctl_in.x_neg && !ctl_in.y_neg) begin
      angle_next = TURN_HALF - a_quad;
    end else if (ctl_in.x_neg) begin
      angle_next = TURN_HALF + a_quad;
    end else begin
      angle_next = TURN_ZERO - a_quad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_in.valid;
    end
    magnitude <= magnitude_next;
    angle_turns <= angle_next;
  end

endmodule

// ===== design/cartesian_to_polar_core.sv =====
// Cartesian to polar converter.
// A point enters as x_coord and y_coord, both signed, and is taken on a clock
// edge where start is high and busy is low. Each accepted beat produces exactly
// one result beat: magnitude (rounded length) and angle_turns (65536 per full
// turn, counterclockwise from +x), shown for one cycle with done high.
// The pipeline has three front stages (absolute values, squares, sum), one cell
// per square root bit and CORDIC micro-rotation, and one output stage for
// rounding and quadrant folding. Every stage is a register, so a new point
// may be taken every cycle and many points are in flight at once.
// busy is high only while rst is asserted. Reset empties the pipeline; points
// in flight are dropped and no done strobe follows them.
// The receiver cannot stall: a result is valid only during its done cycle and
// must be captured then.
module cartesian_to_polar_core
  import c2p_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int ITERATIONS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [COORD_WIDTH-1:0]   x_coord,
  input  logic signed [COORD_WIDTH-1:0]   y_coord,
  output logic                            done,
  output logic [COORD_WIDTH-1:0]          magnitude,
  output logic [ANGLE_WIDTH-1:0]          angle_turns
);

  localparam int SW = 2 * COORD_WIDTH;
  localparam int CW = COORD_WIDTH + GUARD_BITS + 4;
  localparam int CELLS = (COORD_WIDTH > ITERATIONS) ? COORD_WIDTH : ITERATIONS;

  ctrl_t ctl_chain [CELLS+1];
  logic [SW-1:0] rem_chain [CELLS+1];
  logic [SW-1:0] root_chain [CELLS+1];
  logic signed [CW-1:0] cx_chain [CELLS+1];
  logic signed [CW-1:0] cy_chain [CELLS+1];
  logic signed [Z_WIDTH-1:0] z_chain [CELLS+1];
  logic [COORD_WIDTH-1:0] ax, ay;

  assign busy = rst;

  c2p_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .accept(start && !busy),
    .x_coord(x_coord),
    .y_coord(y_coord),
    .ctl_out(ctl_chain[0]),
    .sum_out(rem_chain[0]),
    .ax_out(ax),
    .ay_out(ay)
  );

  assign root_chain[0] = '0;
  assign cx_chain[0] = $signed({{(CW-COORD_WIDTH-GUARD_BITS){1'b0}}, ax, {GUARD_BITS{1'b0}}});
  assign cy_chain[0] = $signed({{(CW-COORD_WIDTH-GUARD_BITS){1'b0}}, ay, {GUARD_BITS{1'b0}}});
  assign z_chain[0] = '0;

  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    c2p_cell #(
      .COORD_WIDTH(COORD_WIDTH),
      .ITERATIONS(ITERATIONS),
      .STEP(g)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .ctl_in(ctl_chain[g]),
      .rem_in(rem_chain[g]),
      .root_in(root_chain[g]),
      .cx_in(cx_chain[g]),
      .cy_in(cy_chain[g]),
      .z_in(z_chain[g]),
      .ctl_out(ctl_chain[g+1]),
      .rem_out(rem_chain[g+1]),
      .root_out(root_chain[g+1]),
      .cx_out(cx_chain[g+1]),
      .cy_out(cy_chain[g+1]),
      .z_out(z_chain[g+1])
    );
  end

  c2p_back #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .ctl_in(ctl_chain[CELLS]),
    .rem_in(rem_chain[CELLS]),
    .root_in(root_chain[CELLS]),
    .z_in(z_chain[CELLS]),
    .done(done),
    .magnitude(magnitude),
    .angle_turns(angle_turns)
  );

endmodule

// ===== dv/polar_checker.sv =====
module polar_checker
  import c2p_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int ITERATIONS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] x_coord,
  input  logic signed [COORD_WIDTH-1:0] y_coord,
  input  logic                          done,
  input  logic [COORD_WIDTH-1:0]        magnitude,
  input  logic [ANGLE_WIDTH-1:0]        angle_turns,
  output int                            failures,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = COORD_WIDTH;
  localparam int AW = ANGLE_WIDTH;
  localparam int CORDIC_GUARD = 28;

  // atan(2^-i) in units of 2^-32 turn.
  localparam longint ATAN_STEP [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1, 0
  };

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [CW-1:0]        mag;
    logic [AW-1:0]        ang;
  } polar_t;

  polar_t awaited_q[$];
  int fail_count = 0;
  int in_flight = 0;

  assign failures = fail_count;
  assign pending = in_flight;

  function automatic polar_t predict_polar(input logic signed [CW-1:0] xc,
                                           input logic signed [CW-1:0] yc);
    polar_t r;
    longint xs, ys, cx, cy, dx, dy, z;
    longint unsigned ax, ay, sum, rem, root, bitv;
    int unsigned turns;
    int steps;
    r.x = xc;
    r.y = yc;
    xs = longint'(xc);
    ys = longint'(yc);
    ax = (xs < 0) ? longint'(-xs) : xs;
    ay = (ys < 0) ? longint'(-ys) : ys;

    // Bitwise integer square root, then round to nearest on the remainder.
    sum = ax * ax + ay * ay;
    rem = sum;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > sum) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    if (rem > root) root = root + 1;
    r.mag = CW'(root);

    if (xs == 0 && ys == 0) begin
      r.ang = TURN_ZERO;
    end else if (xs == 0) begin
      r.ang = (ys > 0) ? TURN_QUARTER : TURN_3QUARTER;
    end else if (ys == 0) begin
      r.ang = (xs > 0) ? TURN_ZERO : TURN_HALF;
    end else begin
      cx = longint'(ax << CORDIC_GUARD);
      cy = longint'(ay << CORDIC_GUARD);
      z = 0;
      steps = (ITERATIONS > 32) ? 32 : ITERATIONS;
      for (int i = 0; i < steps; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy >= 0) begin
          cx = cx + dx;
          cy = cy - dy;
          z = z + ATAN_STEP[i];
        end else begin
          cx = cx - dx;
          cy = cy + dy;
          z = z - ATAN_STEP[i];
        end
      end
      if (z < 0) z = 0;
      if (z > (longint'(1) << 30)) z = longint'(1) << 30;
      turns = 32'((z + 32768) >>> 16);
      if (turns > 32'(TURN_QUARTER)) turns = 32'(TURN_QUARTER);
      if (xs > 0 && ys > 0) r.ang = AW'(turns);
      else if (xs < 0 && ys > 0) r.ang = TURN_HALF - AW'(turns);
      else if (xs < 0) r.ang = TURN_HALF + AW'(turns);
      else r.ang = AW'(32'd65536 - turns);
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    polar_t oldest;
    if (!rst && done) begin
      if (awaited_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: result beat with nothing awaited: magnitude %0d angle %0d",
                   $realtime, magnitude, angle_turns);
      end else begin
        oldest = awaited_q.pop_front();
        if (oldest.mag !== magnitude || oldest.ang !== angle_turns) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: point (%0d, %0d): magnitude exp %0d got %0d, angle exp %0d got %0d",
                     $realtime, oldest.x, oldest.y, oldest.mag, magnitude, oldest.ang,
                     angle_turns);
        end
      end
    end
    if (!rst && start && !busy) awaited_q.push_back(predict_polar(x_coord, y_coord));
    in_flight = awaited_q.size();
  end

endmodule

// ===== dv/tb.sv =====
module tb
  import c2p_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 16;
  localparam int ITER = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_POINTS = 1200;
  localparam int DIRECTED_POINTS = 24;

  localparam int DIRECTED_X [DIRECTED_POINTS] = '{
    0, 1, -1, 0, 0, 32767, -32768, 0, 0, 32767, -32768, -32768,
    32767, 1, -1, -1, 1, 32767, 32767, 1, -32768, -1, 3, -3
  };
  localparam int DIRECTED_Y [DIRECTED_POINTS] = '{
    0, 0, 0, 1, -1, 0, 0, 32767, -32768, 32767, 32767, -32768,
    -32768, 1, 1, -1, -1, 1, -1, 32767, -1, -32768, 4, -4
  };
  localparam int EDGE_VALUES [6] = '{-32768, -32767, -1, 0, 1, 32767};

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic signed [CW-1:0] x_coord;
  logic signed [CW-1:0] y_coord;
  logic                 done;
  logic [CW-1:0]        magnitude;
  logic [ANGLE_WIDTH-1:0] angle_turns;
  int                   failures;
  int                   pending;
  int                   cycle_count = 0;

  cartesian_to_polar_core #(
    .COORD_WIDTH(CW),
    .ITERATIONS(ITER)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .x_coord(x_coord),
    .y_coord(y_coord),
    .done(done),
    .magnitude(magnitude),
    .angle_turns(angle_turns)
  );

  polar_checker #(
    .COORD_WIDTH(CW),
    .ITERATIONS(ITER)
  ) u_polar_checker (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .x_coord(x_coord),
    .y_coord(y_coord),
    .done(done),
    .magnitude(magnitude),
    .angle_turns(angle_turns),
    .failures(failures),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Holds the beat on the ports until an edge with busy low takes it.
  // busy only moves at a rising edge, so it is sampled at the falling edge.
  task automatic send_point(input logic signed [CW-1:0] xv,
                            input logic signed [CW-1:0] yv);
    bit ready;
    start <= 1'b1;
    x_coord <= xv;
    y_coord <= yv;
    do begin
      @(negedge clk);
      ready = !busy;
      @(posedge clk);
    end while (!ready);
  endtask

  task automatic hold_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  initial begin
    int idle_rate;
    int pick;
    int mag;
    logic signed [CW-1:0] xv;
    logic signed [CW-1:0] yv;
    rst <= 1'b1;
    start <= 1'b0;
    x_coord <= '0;
    y_coord <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    idle_rate = 2;
    for (int k = 0; k < DIRECTED_POINTS; k++) begin
      if ($urandom_range(1, 8) <= idle_rate) hold_sender($urandom_range(1, 14));
      send_point(CW'(DIRECTED_X[k]), CW'(DIRECTED_Y[k]));
    end

    for (int n = 0; n < RANDOM_POINTS; n++) begin
      if (n % 100 == 0) idle_rate = $urandom_range(0, 3);
      if (n == RANDOM_POINTS / 2) begin
        start <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
      end
      // The closing stretch runs back to back with no gaps.
      if (n < RANDOM_POINTS - 200 && idle_rate != 0 && $urandom_range(1, 8) <= idle_rate)
        hold_sender($urandom_range(1, 14));
      pick = $urandom_range(0, 9);
      case (pick)
        4: begin
          xv = CW'(int'($urandom_range(0, 16)) - 8);
          yv = CW'(int'($urandom_range(0, 16)) - 8);
        end
        5: begin
          xv = CW'($urandom);
          yv = '0;
          if ($urandom_range(0, 1) == 1) begin
            yv = xv;
            xv = '0;
          end
        end
        6: begin
          mag = $urandom_range(1, 32767);
          xv = CW'(($urandom_range(0, 1) == 1) ? -mag : mag);
          yv = CW'(($urandom_range(0, 1) == 1) ? -mag : mag);
        end
        7: begin
          xv = CW'(EDGE_VALUES[$urandom_range(0, 5)]);
          yv = CW'(EDGE_VALUES[$urandom_range(0, 5)]);
        end
        8: begin
          // Nearly on an axis, where the quadrant angle is close to its limits.
          mag = $urandom_range(1, 3);
          xv = CW'(($urandom_range(0, 1) == 1) ? -mag : mag);
          yv = CW'($urandom);
          if ($urandom_range(0, 1) == 1) begin
            xv = yv;
            yv = CW'(($urandom_range(0, 1) == 1) ? -mag : mag);
          end
        end
        9: begin
          xv = CW'(int'($urandom_range(0, 510)) - 255);
          yv = CW'(int'($urandom_range(0, 510)) - 255);
        end
        default: begin
          xv = CW'($urandom);
          yv = CW'($urandom);
        end
      endcase
      send_point(xv, yv);
    end

    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (30) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
